FILE: sv/bgq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bgq_pkg;

    // field widths
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TAPS_W    = 8;
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 8;

    // mode codes, the codes above multi-tap act as pass-through
    localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRESS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TAP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MULTI = 3'd4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_NEEDED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP     = 2'd3;

    // reset values of the registers
    localparam logic [MODE_W-1:0] MODE_RST        = MODE_PASS;
    localparam logic [TIME_W-1:0] DURATION_RST    = 32'd500000;
    localparam logic [TAPS_W-1:0] TAPS_NEEDED_RST = 8'd2;
    localparam logic [TIME_W-1:0] TAP_GAP_RST     = 32'd300000;

    typedef enum logic [PHASE_W-1:0] {
        PHASE_WAITING   = 2'd0,
        PHASE_STARTED   = 2'd1,
        PHASE_PERFORMED = 2'd2,
        PHASE_CANCELED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] duration_us;
        logic [TAPS_W-1:0] taps_needed;
        logic [TIME_W-1:0] tap_gap_us;
    } cfg_t;

    typedef struct packed {
        logic              was_pressed;
        logic [TIME_W-1:0] elapsed_us;
        logic              done_flag;
        logic [TAPS_W-1:0] tap_progress;
    } gesture_state_t;

endpackage

`default_nettype wire

FILE: sv/button_gesture_qualifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Button gesture qualifier. Each slave-side transaction carries one sample
// of a button: its level and the microseconds since the previous sample.
// Each sample yields exactly one master-side transaction with a phase
// (waiting, started, performed, canceled) chosen by the rule in the mode
// register: pass-through, press, hold, tap or multi-tap.
// The user must write registers through cfg_we / cfg_index / cfg_wdata only
// while no sample is in flight; the block does not enforce this. Index 0
// mode, 1 duration_us, 2 taps_needed, 3 tap_gap_us.
// A sample lands in the input register, then one pass of the rule logic
// (a 32-bit saturating add and compare) writes the result register and
// the gesture state. One sample per cycle is sustained while the receiver
// keeps m_axis_tready high.
// When the receiver stalls, the result register holds and the input
// register takes one more sample; tready drops once both are full.
// Reset clears the gesture state, empties both registers and loads the
// register defaults (pass-through, 500000 us, 2 taps, 300000 us).

module button_gesture_qualifier_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [bgq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bgq_pkg::CFG_W-1:0]         cfg_wdata,
    // sample stream
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [bgq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [0] pressed, [16:1] delta_us
    // result stream
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [bgq_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // [1:0] phase
);

    bgq_pkg::cfg_t                    cfg_reg;
    bgq_pkg::gesture_state_t          state_reg;
    bgq_pkg::gesture_state_t          state_next;
    bgq_pkg::phase_t                  phase_next;
    bgq_pkg::phase_t                  out_phase_reg;
    logic                             in_valid_reg;
    logic                             in_pressed_reg;
    logic [bgq_pkg::DELTA_W-1:0]      in_delta_reg;
    logic                             out_valid_reg;
    logic                             advance;
    logic                             in_take;

    // handshake: the input register moves on when the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(bgq_pkg::OUT_DATA_W - bgq_pkg::PHASE_W){1'b0}}, out_phase_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= bgq_pkg::MODE_RST;
            cfg_reg.duration_us <= bgq_pkg::DURATION_RST;
            cfg_reg.taps_needed <= bgq_pkg::TAPS_NEEDED_RST;
            cfg_reg.tap_gap_us  <= bgq_pkg::TAP_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bgq_pkg::CFG_MODE:        cfg_reg.mode        <= cfg_wdata[bgq_pkg::MODE_W-1:0];
                bgq_pkg::CFG_DURATION:    cfg_reg.duration_us <= cfg_wdata[bgq_pkg::TIME_W-1:0];
                bgq_pkg::CFG_TAPS_NEEDED: cfg_reg.taps_needed <= cfg_wdata[bgq_pkg::TAPS_W-1:0];
                bgq_pkg::CFG_TAP_GAP:     cfg_reg.tap_gap_us  <= cfg_wdata[bgq_pkg::TIME_W-1:0];
                default:                  ;
            endcase
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_pressed_reg <= s_axis_tdata[0];
            in_delta_reg   <= s_axis_tdata[bgq_pkg::DELTA_W:1];
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg <= phase_next;
        end
    end

    // valid flags and gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    bgq_rule u_rule
    (
        .cfg      (cfg_reg),
        .cur      (state_reg),
        .pressed  (in_pressed_reg),
        .delta_us (in_delta_reg),
        .nxt      (state_next),
        .phase    (phase_next)
    );

endmodule

`default_nettype wire

FILE: sv/bgq_rule.sv
`timescale 1ns / 1ps
`default_nettype none

module bgq_rule
(
    input  wire bgq_pkg::cfg_t            cfg,
    input  wire bgq_pkg::gesture_state_t  cur,
    input  wire logic                     pressed,
    input  wire logic [bgq_pkg::DELTA_W-1:0] delta_us,
    output bgq_pkg::gesture_state_t       nxt,
    output bgq_pkg::phase_t               phase
);

    logic [bgq_pkg::TIME_W:0]   sum;
    logic [bgq_pkg::TIME_W-1:0] added;
    logic [bgq_pkg::TAPS_W-1:0] tap_inc;

    // saturating time accumulation
    assign sum     = {1'b0, cur.elapsed_us}
                   + {{(bgq_pkg::TIME_W + 1 - bgq_pkg::DELTA_W){1'b0}}, delta_us};
    assign added   = sum[bgq_pkg::TIME_W] ? '1 : sum[bgq_pkg::TIME_W-1:0];
    assign tap_inc = cur.tap_progress + 8'd1;

    // per-mode gesture rules
    always_comb
    begin
        nxt   = cur;
        phase = bgq_pkg::PHASE_WAITING;
        unique case (cfg.mode)
            bgq_pkg::MODE_PRESS:
            begin
                if (pressed)
                begin
                    nxt.was_pressed = 1'b1;
                    phase = cur.was_pressed ? bgq_pkg::PHASE_STARTED
                                            : bgq_pkg::PHASE_PERFORMED;
                end
                else if (cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b0;
                    phase = bgq_pkg::PHASE_CANCELED;
                end
            end
            bgq_pkg::MODE_HOLD:
            begin
                if (pressed && !cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b1;
                    nxt.elapsed_us  = '0;
                    nxt.done_flag   = 1'b0;
                    phase = bgq_pkg::PHASE_STARTED;
                end
                else if (pressed)
                begin
                    nxt.elapsed_us = added;
                    if (!cur.done_flag && added >= cfg.duration_us)
                    begin
                        nxt.done_flag = 1'b1;
                        phase = bgq_pkg::PHASE_PERFORMED;
                    end
                    else
                    begin
                        phase = bgq_pkg::PHASE_STARTED;
                    end
                end
                else if (cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b0;
                    nxt.done_flag   = 1'b0;
                    phase = bgq_pkg::PHASE_CANCELED;
                end
            end
            bgq_pkg::MODE_TAP:
            begin
                if (pressed && !cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b1;
                    nxt.elapsed_us  = '0;
                    nxt.done_flag   = 1'b0;
                    phase = bgq_pkg::PHASE_STARTED;
                end
                else if (pressed)
                begin
                    nxt.elapsed_us = added;
                    if (!cur.done_flag && added > cfg.duration_us)
                    begin
                        nxt.done_flag = 1'b1;
                        phase = bgq_pkg::PHASE_CANCELED;
                    end
                    else
                    begin
                        phase = cur.done_flag ? bgq_pkg::PHASE_WAITING
                                              : bgq_pkg::PHASE_STARTED;
                    end
                end
                else if (cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b0;
                    nxt.done_flag   = 1'b0;
                    phase = (!cur.done_flag && cur.elapsed_us <= cfg.duration_us)
                          ? bgq_pkg::PHASE_PERFORMED : bgq_pkg::PHASE_WAITING;
                end
            end
            bgq_pkg::MODE_MULTI:
            begin
                if (pressed && !cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b1;
                    nxt.elapsed_us  = '0;
                    phase = bgq_pkg::PHASE_STARTED;
                end
                else if (!pressed && cur.was_pressed)
                begin
                    // release edge counts one tap
                    nxt.was_pressed = 1'b0;
                    nxt.elapsed_us  = '0;
                    if (tap_inc >= cfg.taps_needed)
                    begin
                        nxt.tap_progress = '0;
                        phase = bgq_pkg::PHASE_PERFORMED;
                    end
                    else
                    begin
                        nxt.tap_progress = tap_inc;
                        phase = bgq_pkg::PHASE_STARTED;
                    end
                end
                else
                begin
                    nxt.elapsed_us = added;
                    if (cur.tap_progress != '0 && added > cfg.tap_gap_us)
                    begin
                        nxt.tap_progress = '0;
                        phase = bgq_pkg::PHASE_CANCELED;
                    end
                    else
                    begin
                        phase = cur.was_pressed ? bgq_pkg::PHASE_STARTED
                                                : bgq_pkg::PHASE_WAITING;
                    end
                end
            end
            default:
            begin
                // pass-through, also for the unused mode codes
                if (pressed)
                begin
                    nxt.was_pressed = 1'b1;
                    phase = bgq_pkg::PHASE_PERFORMED;
                end
                else if (cur.was_pressed)
                begin
                    nxt.was_pressed = 1'b0;
                    phase = bgq_pkg::PHASE_CANCELED;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: dv/button_gesture_qualifier_core_tb.sv
`timescale 1ns / 1ps

module button_gesture_qualifier_core_tb;

    typedef logic [bgq_pkg::MODE_W-1:0]    mode_code_t;
    typedef logic [bgq_pkg::TIME_W-1:0]    time_us_t;
    typedef logic [bgq_pkg::TAPS_W-1:0]    tap_count_t;
    typedef logic [bgq_pkg::DELTA_W-1:0]   delta_t;
    typedef logic [bgq_pkg::CFG_W-1:0]     cfg_word_t;
    typedef logic [bgq_pkg::IN_DATA_W-1:0] in_word_t;

    // mode codes above multi-tap fall back to pass-through
    localparam mode_code_t  MODE_UNUSED_TOP = 3'd7;
    localparam int unsigned RANDOM_ITEMS  = 1580;
    localparam int unsigned QUIET_LIMIT   = 1000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PRINT_LIMIT   = 100;

    typedef struct packed {
        logic   pressed;
        delta_t delta_us;
    } sample_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [bgq_pkg::CFG_IDX_W-1:0]         cfg_index = bgq_pkg::CFG_MODE;
    logic [bgq_pkg::CFG_W-1:0]             cfg_wdata = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [bgq_pkg::IN_DATA_W-1:0]         s_axis_tdata = '0;   // [0] pressed, [16:1] delta_us
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [bgq_pkg::OUT_DATA_W-1:0]        m_axis_tdata;        // [1:0] phase

    // gesture tracker state and its copy of the registers
    mode_code_t  mode_sel;
    time_us_t    dur_limit_us;
    tap_count_t  taps_goal;
    time_us_t    gap_limit_us;
    logic        btn_down;
    time_us_t    hold_time_us;
    logic        gesture_closed;
    tap_count_t  taps_seen;

    sample_t           sample_queue[$];
    bgq_pkg::phase_t   expected_phases[$];
    bgq_pkg::phase_t   due_phase;
    sample_t           cur_sample;
    int unsigned queued_total = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned feed_gap = 0;
    int unsigned drain_stall = 0;
    bit          feed_calm = 1'b0;
    bit          drain_calm = 1'b0;
    bit          hurry = 1'b0;
    bit          sample_taken = 1'b0;
    bit          result_taken = 1'b0;

    button_gesture_qualifier_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic time_us_t add_sat(input time_us_t acc, input delta_t d);
        logic [bgq_pkg::TIME_W:0] sum;
        sum = {1'b0, acc} + {{(bgq_pkg::TIME_W + 1 - bgq_pkg::DELTA_W){1'b0}}, d};
        return sum[bgq_pkg::TIME_W] ? '1 : sum[bgq_pkg::TIME_W-1:0];
    endfunction

    // phase for one sample under the current rule, advances the tracker state
    function automatic bgq_pkg::phase_t qualify_sample(input logic pressed,
                                                       input delta_t delta_us);
        bgq_pkg::phase_t ph;
        ph = bgq_pkg::PHASE_WAITING;
        case (mode_sel)
            bgq_pkg::MODE_HOLD:
            begin
                if (pressed && !btn_down)
                begin
                    btn_down = 1'b1;
                    hold_time_us = '0;
                    gesture_closed = 1'b0;
                    ph = bgq_pkg::PHASE_STARTED;
                end
                else if (pressed)
                begin
                    hold_time_us = add_sat(hold_time_us, delta_us);
                    if (!gesture_closed && hold_time_us >= dur_limit_us)
                    begin
                        gesture_closed = 1'b1;
                        ph = bgq_pkg::PHASE_PERFORMED;
                    end
                    else
                    begin
                        ph = bgq_pkg::PHASE_STARTED;
                    end
                end
                else if (btn_down)
                begin
                    btn_down = 1'b0;
                    gesture_closed = 1'b0;
                    ph = bgq_pkg::PHASE_CANCELED;
                end
            end
            bgq_pkg::MODE_TAP:
            begin
                if (pressed && !btn_down)
                begin
                    btn_down = 1'b1;
                    hold_time_us = '0;
                    gesture_closed = 1'b0;
                    ph = bgq_pkg::PHASE_STARTED;
                end
                else if (pressed)
                begin
                    hold_time_us = add_sat(hold_time_us, delta_us);
                    if (!gesture_closed && hold_time_us > dur_limit_us)
                    begin
                        gesture_closed = 1'b1;
                        ph = bgq_pkg::PHASE_CANCELED;
                    end
                    else
                    begin
                        ph = gesture_closed ? bgq_pkg::PHASE_WAITING
                                            : bgq_pkg::PHASE_STARTED;
                    end
                end
                else if (btn_down)
                begin
                    // a tap counts only if it never ran over the limit
                    if (!gesture_closed && hold_time_us <= dur_limit_us)
                        ph = bgq_pkg::PHASE_PERFORMED;
                    btn_down = 1'b0;
                    gesture_closed = 1'b0;
                end
            end
            bgq_pkg::MODE_MULTI:
            begin
                if (pressed && !btn_down)
                begin
                    btn_down = 1'b1;
                    hold_time_us = '0;
                    ph = bgq_pkg::PHASE_STARTED;
                end
                else if (!pressed && btn_down)
                begin
                    btn_down = 1'b0;
                    hold_time_us = '0;
                    taps_seen = taps_seen + 8'd1;
                    if (taps_seen >= taps_goal)
                    begin
                        taps_seen = '0;
                        ph = bgq_pkg::PHASE_PERFORMED;
                    end
                    else
                    begin
                        ph = bgq_pkg::PHASE_STARTED;
                    end
                end
                else
                begin
                    hold_time_us = add_sat(hold_time_us, delta_us);
                    if (taps_seen != '0 && hold_time_us > gap_limit_us)
                    begin
                        taps_seen = '0;
                        ph = bgq_pkg::PHASE_CANCELED;
                    end
                    else
                    begin
                        ph = btn_down ? bgq_pkg::PHASE_STARTED : bgq_pkg::PHASE_WAITING;
                    end
                end
            end
            default:
            begin
                // pass-through, press and the unused codes
                if (pressed)
                begin
                    ph = (mode_sel == bgq_pkg::MODE_PRESS && btn_down)
                       ? bgq_pkg::PHASE_STARTED : bgq_pkg::PHASE_PERFORMED;
                    btn_down = 1'b1;
                end
                else if (btn_down)
                begin
                    btn_down = 1'b0;
                    ph = bgq_pkg::PHASE_CANCELED;
                end
            end
        endcase
        return ph;
    endfunction

    // wait before the next transaction, with runs of back-to-back traffic
    function automatic int unsigned pick_wait(inout bit calm);
        if ($urandom_range(0, 23) == 0)
            calm = !calm;
        if (hurry || calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic delta_t pick_delta(input int unsigned scale);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return delta_t'($urandom);
            default: return delta_t'($urandom_range(0, scale));
        endcase
    endfunction

    function automatic time_us_t pick_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return time_us_t'($urandom_range(0, 1000));
            3: return time_us_t'($urandom);
            default: return time_us_t'($urandom_range(0, 200000));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_sample(input logic pressed, input delta_t delta_us);
        sample_queue.push_back('{pressed: pressed, delta_us: delta_us});
        queued_total++;
    endtask

    // returns at a falling edge once every sample has been answered,
    // checked at the rising edge where the driver's outputs are settled
    task automatic wait_idle();
        @(posedge clk);
        while (sample_queue.size() != 0 || s_axis_tvalid || expected_phases.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [bgq_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            bgq_pkg::CFG_MODE:        mode_sel = value[bgq_pkg::MODE_W-1:0];
            bgq_pkg::CFG_DURATION:    dur_limit_us = value[bgq_pkg::TIME_W-1:0];
            bgq_pkg::CFG_TAPS_NEEDED: taps_goal = value[bgq_pkg::TAPS_W-1:0];
            bgq_pkg::CFG_TAP_GAP:     gap_limit_us = value[bgq_pkg::TIME_W-1:0];
            default:                  ;
        endcase
        @(negedge clk);
    endtask

    // write the selected registers, called only while idle
    task automatic program_regs(input logic [3:0] which, input mode_code_t mode,
                                input time_us_t dur, input tap_count_t taps,
                                input time_us_t gap);
        if (which[0])
            write_reg(bgq_pkg::CFG_MODE, cfg_word_t'(mode));
        if (which[1])
            write_reg(bgq_pkg::CFG_DURATION, cfg_word_t'(dur));
        if (which[2])
            write_reg(bgq_pkg::CFG_TAPS_NEEDED, cfg_word_t'(taps));
        if (which[3])
            write_reg(bgq_pkg::CFG_TAP_GAP, cfg_word_t'(gap));
        cfg_we <= 1'b0;
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || sample_taken)
        begin
            if (sample_taken)
                feed_gap = pick_wait(feed_calm);
            if (feed_gap > 0 || sample_queue.size() == 0)
            begin
                if (feed_gap > 0)
                    feed_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                cur_sample = sample_queue.pop_front();
                s_axis_tdata <= in_word_t'({cur_sample.delta_us, cur_sample.pressed});
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result receiver backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (result_taken)
                drain_stall = pick_wait(drain_calm);
            if (drain_stall > 0)
            begin
                drain_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: check results, predict accepted samples, watchdog
    always @(posedge clk)
    begin
        sample_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        result_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_phases.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing pending, data %0h",
                                              results_seen, m_axis_tdata));
                end
                else
                begin
                    due_phase = expected_phases.pop_front();
                    if (m_axis_tdata[bgq_pkg::PHASE_W-1:0] !== due_phase)
                        report_mismatch($sformatf("result %0d phase %0d, want %0d",
                                                  results_seen,
                                                  m_axis_tdata[bgq_pkg::PHASE_W-1:0],
                                                  due_phase));
                    if (m_axis_tdata[bgq_pkg::OUT_DATA_W-1:bgq_pkg::PHASE_W] !== '0)
                        report_mismatch($sformatf("result %0d padding %0h", results_seen,
                                        m_axis_tdata[bgq_pkg::OUT_DATA_W-1:bgq_pkg::PHASE_W]));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_phases.push_back(qualify_sample(s_axis_tdata[0],
                                                         s_axis_tdata[bgq_pkg::DELTA_W:1]));
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned base;
        int unsigned target;
        int unsigned scale;

        mode_sel = bgq_pkg::MODE_RST;
        dur_limit_us = bgq_pkg::DURATION_RST;
        taps_goal = bgq_pkg::TAPS_NEEDED_RST;
        gap_limit_us = bgq_pkg::TAP_GAP_RST;
        btn_down = 1'b0;
        hold_time_us = '0;
        gesture_closed = 1'b0;
        taps_seen = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pass-through on the reset settings, all delta bits both ways
        push_sample(1'b0, 16'h0000);
        push_sample(1'b1, 16'hFFFF);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b0, 16'hAAAA);
        push_sample(1'b0, 16'h5555);
        wait_idle();

        // press edge, held, release
        program_regs(4'b0001, bgq_pkg::MODE_PRESS, '0, '0, '0);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'h0001);
        push_sample(1'b0, 16'h0000);
        wait_idle();

        // hold with a zero threshold fires on the first held sample
        program_regs(4'b0011, bgq_pkg::MODE_HOLD, '0, '0, '0);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'hFFFF);
        push_sample(1'b0, 16'h0000);
        wait_idle();

        // tap with zero duration: good tap, then one that runs over
        program_regs(4'b0001, bgq_pkg::MODE_TAP, '0, '0, '0);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b0, 16'h0000);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'h0001);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b0, 16'h0000);
        wait_idle();

        // multi-tap with zero taps needed: every release completes
        program_regs(4'b1101, bgq_pkg::MODE_MULTI, '0, 8'd0, '0);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b0, 16'h0000);
        push_sample(1'b0, 16'h0001);
        wait_idle();

        // highest unused mode code behaves as pass-through
        program_regs(4'b0001, MODE_UNUSED_TOP, '0, '0, '0);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b0, 16'h0000);
        wait_idle();

        // hold fires exactly when the largest deltas add up to the threshold
        hurry = 1'b1;
        program_regs(4'b0011, bgq_pkg::MODE_HOLD, 32'h0003_FFFC, '0, '0);
        push_sample(1'b1, 16'h0000);
        repeat (5) push_sample(1'b1, 16'hFFFF);
        push_sample(1'b0, 16'h0000);
        wait_idle();
        hurry = 1'b0;

        // random part, opening with the largest tap count
        base = queued_total;
        program_regs(4'b1111, bgq_pkg::MODE_MULTI, pick_limit(), 8'd255, '1);
        repeat (255)
        begin
            push_sample(1'b1, pick_delta(65535));
            if ($urandom_range(0, 1) == 0)
                push_sample(1'b1, pick_delta(65535));
            push_sample(1'b0, pick_delta(65535));
        end

        while (queued_total - base < RANDOM_ITEMS)
        begin
            wait_idle();
            program_regs(4'($urandom_range(1, 15)),
                         ($urandom_range(0, 2) == 0)
                             ? mode_code_t'($urandom_range(0, 7))
                             : mode_code_t'($urandom_range(bgq_pkg::MODE_HOLD,
                                                           bgq_pkg::MODE_MULTI)),
                         pick_limit(),
                         ($urandom_range(0, 9) == 0) ? 8'd0
                                                     : tap_count_t'($urandom_range(1, 4)),
                         pick_limit());
            case ($urandom_range(0, 2))
                0: scale = 100;
                1: scale = 5000;
                default: scale = 65535;
            endcase
            target = queued_total + $urandom_range(30, 100);
            while (queued_total < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray sample, may leave the button held across a mode change
                    push_sample(1'($urandom_range(0, 1)), pick_delta(scale));
                end
                else
                begin
                    push_sample(1'b1, pick_delta(scale));
                    repeat ($urandom_range(0, 8)) push_sample(1'b1, pick_delta(scale));
                    repeat ($urandom_range(1, 4)) push_sample(1'b0, pick_delta(scale));
                end
            end
        end

        // drain and let any stray result show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
